@@ rtl/rrts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared types and codes for the scheduler's thread table and operations.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int SPAWN_IDS = 100;

  typedef enum logic [2:0] {
    OP_SPAWN     = 3'd0,
    OP_TERMINATE = 3'd1,
    OP_BLOCK     = 3'd2,
    OP_RESUME    = 3'd3,
    OP_SWITCH    = 3'd4,
    OP_TICK      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_BLOCKED = 2'd2
  } ts_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_IGNORED   = 2'd3
  } st_t;

  typedef struct packed {
    logic        present;
    ts_t         tstatus;
    logic        sleeping;
    logic [15:0] sleep_left;
    logic [31:0] quanta;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SP_RD,
    S_SP_CHK,
    S_ID_RD,
    S_ID_CHK,
    S_RM_RD,
    S_RM_CHK,
    S_SH_RD,
    S_SH_WR,
    S_SW_RD,
    S_SW_CUR,
    S_SW_POP,
    S_SW_POPD,
    S_Q_RD,
    S_Q_WR,
    S_TK_RD,
    S_TK_CHK,
    S_FN_RD,
    S_FN_OUT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/round_robin_thread_scheduler_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Thread table and ready queue in synchronous memories, driven by a sequencer.
// ----------------------------------------------------------------------------
// Each transaction on the input stream is one operation and yields exactly one
// result transaction. Operations are handled one at a time by a sequencer that
// walks the thread table memory and the ready queue memory, each with one
// registered read port, so every entry visited takes a read state and then a
// check or write state. A new operation is accepted only once the previous
// result has been loaded into the result register. A spawn searches at most
// min(100, MAX_THREADS) table entries, a tick visits every table entry, and a
// terminate or block walks the queued threads and shifts the ready queue.
// Table entries carry valid bits, so no clearing pass follows reset.
module round_robin_thread_scheduler_unit
  import rrts_pkg::*;
#(
  parameter int MAX_THREADS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // operation[2:0], thread_id[9:3], sleep_flag[10], block_flag[11],
  // terminate_flag[12], sleep_ticks[28:13], zero fill
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[1:0], result_id[8:2], running_id[15:9], running_quanta[47:16]
  output logic [47:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IDW       = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CW        = $clog2(MAX_THREADS + 1);
  localparam int SPAWN_LIM = (MAX_THREADS < SPAWN_IDS) ? MAX_THREADS : SPAWN_IDS;

  function automatic logic [IDW-1:0] slot(input logic [IDW-1:0] hd,
                                          input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(hd) + (CW+1)'(off);
    if (s >= (CW+1)'(MAX_THREADS)) s = s - (CW+1)'(MAX_THREADS);
    return s[IDW-1:0];
  endfunction

  state_t state, state_next;

  logic [7:0]     wake_level;
  logic [2:0]     op;
  logic [6:0]     tid;
  logic           sl, bl, te;
  logic [15:0]    ticks;
  logic [IDW-1:0] tid_a;
  logic           tid_ok;

  logic [IDW-1:0] current, current_next;
  logic [IDW-1:0] head, head_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  idx, idx_next;
  logic [IDW-1:0] qid, qid_next;
  logic           qrun, qrun_next;
  st_t            status, status_next;
  logic [6:0]     rid, rid_next;

  entry_t         tbl_mem [MAX_THREADS];
  logic [MAX_THREADS-1:0] vld;
  entry_t         tbl_q, rd_e, wr_e;
  logic           tbl_vq;
  logic [IDW-1:0] tbl_aq;
  logic           tbl_re, tbl_we;
  logic [IDW-1:0] tbl_raddr, tbl_waddr;

  logic [IDW-1:0] ff_mem [MAX_THREADS];
  logic [IDW-1:0] ff_q;
  logic           ff_re, ff_we;
  logic [IDW-1:0] ff_raddr, ff_waddr, ff_wdata;

  logic           out_load;
  logic           empty;

  assign tid_a  = IDW'(tid);
  assign tid_ok = (32'(tid) < MAX_THREADS);
  assign empty  = (count == '0);

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr == 3'd0) ? {24'd0, wake_level} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_level <= 8'd0;
    end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
      wake_level <= pwdata[7:0];
    end
  end

  // Table memory with valid bits standing in for the reset contents.
  always_ff @(posedge clk) begin
    if (tbl_re) begin
      tbl_q  <= tbl_mem[tbl_raddr];
      tbl_vq <= vld[tbl_raddr];
      tbl_aq <= tbl_raddr;
    end
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= wr_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (tbl_we) begin
      vld[tbl_waddr] <= 1'b1;
    end
  end

  always_comb begin
    if (tbl_vq) begin
      rd_e = tbl_q;
    end else begin
      rd_e.present    = (tbl_aq == '0);
      rd_e.tstatus    = (tbl_aq == '0) ? TS_RUNNING : TS_READY;
      rd_e.sleeping   = 1'b0;
      rd_e.sleep_left = 16'd0;
      rd_e.quanta     = (tbl_aq == '0) ? 32'd1 : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (ff_re) begin
      ff_q <= ff_mem[ff_raddr];
    end
    if (ff_we) begin
      ff_mem[ff_waddr] <= ff_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      current <= '0;
      head    <= '0;
      count   <= '0;
    end else begin
      state   <= state_next;
      current <= current_next;
      head    <= head_next;
      count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op    <= s_tdata[2:0];
      tid   <= s_tdata[9:3];
      sl    <= s_tdata[10];
      bl    <= s_tdata[11];
      te    <= s_tdata[12];
      ticks <= s_tdata[28:13];
    end
    idx    <= idx_next;
    qid    <= qid_next;
    qrun   <= qrun_next;
    status <= status_next;
    rid    <= rid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {rd_e.quanta, 7'(current), rid, status};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (s_tvalid) state_next = S_DECODE;
      S_DECODE: begin
        case (op)
          OP_SPAWN:  state_next = S_SP_RD;
          OP_TERMINATE, OP_BLOCK, OP_RESUME:
                     state_next = tid_ok ? S_ID_RD : S_FN_RD;
          OP_SWITCH: state_next = S_SW_RD;
          OP_TICK:   state_next = S_TK_RD;
          default:   state_next = S_FN_RD;
        endcase
      end
      S_SP_RD:   state_next = (idx >= CW'(SPAWN_LIM)) ? S_FN_RD : S_SP_CHK;
      S_SP_CHK:  state_next = rd_e.present ? S_SP_RD : S_FN_RD;
      S_ID_RD:   state_next = S_ID_CHK;
      S_ID_CHK: begin
        if (rd_e.present && (op == OP_TERMINATE || op == OP_BLOCK)) begin
          state_next = S_RM_RD;
        end else begin
          state_next = S_FN_RD;
        end
      end
      S_RM_RD:   state_next = (idx >= count) ? S_FN_RD : S_RM_CHK;
      S_RM_CHK:  state_next = (ff_q == tid_a) ? S_SH_RD : S_RM_RD;
      S_SH_RD:   state_next = ((CW+1)'(idx) + 1'b1 >= (CW+1)'(count)) ? S_FN_RD : S_SH_WR;
      S_SH_WR:   state_next = S_SH_RD;
      S_SW_RD:   state_next = S_SW_CUR;
      S_SW_CUR:  state_next = empty ? S_Q_RD : S_SW_POP;
      S_SW_POP:  state_next = S_SW_POPD;
      S_SW_POPD: state_next = S_Q_RD;
      S_Q_RD:    state_next = S_Q_WR;
      S_Q_WR:    state_next = S_FN_RD;
      S_TK_RD:   state_next = (idx >= CW'(MAX_THREADS)) ? S_FN_RD : S_TK_CHK;
      S_TK_CHK:  state_next = S_TK_RD;
      S_FN_RD:   state_next = S_FN_OUT;
      S_FN_OUT:  if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    current_next = current;
    head_next    = head;
    count_next   = count;
    idx_next     = idx;
    qid_next     = qid;
    qrun_next    = qrun;
    status_next  = status;
    rid_next     = rid;
    tbl_re       = 1'b0;
    tbl_raddr    = tid_a;
    tbl_we       = 1'b0;
    tbl_waddr    = tid_a;
    wr_e         = rd_e;
    ff_re        = 1'b0;
    ff_raddr     = head;
    ff_we        = 1'b0;
    ff_waddr     = slot(head, count);
    ff_wdata     = tid_a;
    out_load     = 1'b0;
    case (state)
      S_DECODE: begin
        idx_next    = '0;
        status_next = ST_OK;
        rid_next    = tid;
        if (op == OP_TERMINATE || op == OP_BLOCK || op == OP_RESUME) begin
          if (!tid_ok) status_next = ST_NOT_FOUND;
        end else if (op != OP_SPAWN && op != OP_SWITCH && op != OP_TICK) begin
          status_next = ST_IGNORED;
        end
      end
      S_SP_RD: begin
        if (idx >= CW'(SPAWN_LIM)) begin
          status_next = ST_FULL;
        end else begin
          tbl_re    = 1'b1;
          tbl_raddr = idx[IDW-1:0];
        end
      end
      S_SP_CHK: begin
        if (!rd_e.present) begin
          wr_e.present  = 1'b1;
          wr_e.tstatus  = TS_READY;
          wr_e.sleeping = 1'b0;
          wr_e.quanta   = 32'd0;
          tbl_we        = 1'b1;
          tbl_waddr     = idx[IDW-1:0];
          rid_next      = 7'(idx);
          if (count < CW'(MAX_THREADS)) begin
            ff_we      = 1'b1;
            ff_wdata   = idx[IDW-1:0];
            count_next = count + 1'b1;
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_ID_RD: begin
        tbl_re = 1'b1;
      end
      S_ID_CHK: begin
        if (!rd_e.present) begin
          status_next = ST_NOT_FOUND;
        end else if (op == OP_TERMINATE) begin
          wr_e.present  = 1'b0;
          wr_e.sleeping = 1'b0;
          tbl_we        = 1'b1;
        end else if (op == OP_BLOCK) begin
          wr_e.tstatus = TS_BLOCKED;
          tbl_we       = 1'b1;
        end else if (rd_e.tstatus != TS_BLOCKED) begin
          status_next = ST_IGNORED;
        end else if (tid_a == current) begin
          wr_e.tstatus = TS_RUNNING;
          tbl_we       = 1'b1;
        end else begin
          wr_e.tstatus = TS_READY;
          tbl_we       = 1'b1;
          if (!rd_e.sleeping && count < CW'(MAX_THREADS)) begin
            ff_we      = 1'b1;
            count_next = count + 1'b1;
          end
        end
      end
      S_RM_RD: begin
        if (idx < count) begin
          ff_re    = 1'b1;
          ff_raddr = slot(head, idx);
        end
      end
      S_RM_CHK: begin
        if (ff_q != tid_a) idx_next = idx + 1'b1;
      end
      S_SH_RD: begin
        if ((CW+1)'(idx) + 1'b1 >= (CW+1)'(count)) begin
          count_next = count - 1'b1;
        end else begin
          ff_re    = 1'b1;
          ff_raddr = slot(head, idx + 1'b1);
        end
      end
      S_SH_WR: begin
        ff_we    = 1'b1;
        ff_waddr = slot(head, idx);
        ff_wdata = ff_q;
        idx_next = idx + 1'b1;
      end
      S_SW_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = current;
      end
      S_SW_CUR: begin
        tbl_we    = 1'b1;
        tbl_waddr = current;
        if (sl) begin
          wr_e.sleeping   = 1'b1;
          wr_e.sleep_left = ticks;
        end
        if (empty && te && current != '0) begin
          qid_next     = '0;
          qrun_next    = 1'b1;
          current_next = '0;
        end else if (empty) begin
          qid_next  = current;
          qrun_next = 1'b0;
        end else begin
          if (!(sl || bl || te)) begin
            wr_e.tstatus = TS_READY;
            if (count < CW'(MAX_THREADS)) begin
              ff_we      = 1'b1;
              ff_wdata   = current;
              count_next = count + 1'b1;
            end
          end
          if (bl) wr_e.tstatus = TS_BLOCKED;
        end
      end
      S_SW_POP: begin
        ff_re      = 1'b1;
        ff_raddr   = head;
        head_next  = slot(head, CW'(1));
        count_next = count - 1'b1;
      end
      S_SW_POPD: begin
        qid_next     = ff_q;
        qrun_next    = 1'b1;
        current_next = ff_q;
      end
      S_Q_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = qid;
      end
      S_Q_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = qid;
        if (qrun) wr_e.tstatus = TS_RUNNING;
        if (rd_e.quanta != 32'hFFFF_FFFF) wr_e.quanta = rd_e.quanta + 32'd1;
      end
      S_TK_RD: begin
        if (idx < CW'(MAX_THREADS)) begin
          tbl_re    = 1'b1;
          tbl_raddr = idx[IDW-1:0];
        end
      end
      S_TK_CHK: begin
        idx_next  = idx + 1'b1;
        tbl_waddr = idx[IDW-1:0];
        if (rd_e.sleeping) begin
          tbl_we = 1'b1;
          if (rd_e.sleep_left == 16'(wake_level)) begin
            wr_e.sleeping = 1'b0;
            if (rd_e.tstatus != TS_BLOCKED && idx[IDW-1:0] != current) begin
              wr_e.tstatus = TS_READY;
              if (count < CW'(MAX_THREADS)) begin
                ff_we      = 1'b1;
                ff_wdata   = idx[IDW-1:0];
                count_next = count + 1'b1;
              end
            end
          end else begin
            wr_e.sleep_left = rd_e.sleep_left - 16'd1;
          end
        end
      end
      S_FN_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = current;
      end
      S_FN_OUT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_THREADS))
    else $error("ready queue count exceeds its depth");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    32'(head) < MAX_THREADS)
    else $error("ready queue head out of range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FN_OUT))
    else $error("result presented outside the final state");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_DECODE))
    else $error("accepted transaction not decoded");
`endif

endmodule
`default_nettype wire

@@ sim/round_robin_thread_scheduler_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Round-robin thread scheduler testbench
// Drives scheduler operations through the input stream under random
// back-pressure, predicts every result from a model of the thread table and
// ready queue kept here, and checks the result stream field by field. The
// wake level is changed over the APB port between phases, once the block is
// idle.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_unit_tb;
  import rrts_pkg::*;

  localparam int NTHR     = 128;
  localparam int QUIET    = 300;
  localparam int WDOG_MAX = 20000;
  localparam logic [2:0] WAKE_ADDR = 3'd0;

  typedef struct {
    op_t         op;
    bit   [6:0]  tid;
    bit          sl;
    bit          bl;
    bit          te;
    bit   [15:0] ticks;
  } sched_op_t;

  typedef struct {
    st_t         status;
    bit   [6:0]  rid;
    bit   [6:0]  run;
    bit   [31:0] quanta;
  } sched_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  round_robin_thread_scheduler_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Scheduler state as predicted.
  bit   [7:0]  wake_lvl;
  bit          present [NTHR];
  ts_t         tstat [NTHR];
  bit          asleep [NTHR];
  bit   [15:0] sleep_cnt [NTHR];
  bit   [31:0] quanta [NTHR];
  bit   [6:0]  ready_q [NTHR];
  bit   [6:0]  rq_head;
  int          rq_count;
  bit   [6:0]  running;

  sched_op_t   op_queue[$];
  sched_res_t  expected_res[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          op_taken = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic sched_op_t take_op();
    sched_op_t it;
    it = op_queue[0];
    op_queue.delete(0);
    return it;
  endfunction

  function automatic void rq_push(bit [6:0] id);
    if (rq_count < NTHR) begin
      ready_q[(rq_head + rq_count) % NTHR] = id;
      rq_count++;
    end
  endfunction

  function automatic void rq_remove(bit [6:0] id);
    int k;
    int j;
    for (k = 0; k < rq_count; k++) begin
      if (ready_q[(rq_head + k) % NTHR] == id) begin
        for (j = k; j + 1 < rq_count; j++)
          ready_q[(rq_head + j) % NTHR] = ready_q[(rq_head + j + 1) % NTHR];
        rq_count--;
        return;
      end
    end
  endfunction

  function automatic void add_quantum(bit [6:0] id);
    if (quanta[id] != 32'hFFFF_FFFF) quanta[id]++;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < NTHR; i++) begin
      present[i] = 1'b0;
      tstat[i] = TS_READY;
      asleep[i] = 1'b0;
      sleep_cnt[i] = '0;
      quanta[i] = '0;
      ready_q[i] = '0;
    end
    wake_lvl = '0;
    rq_head = '0;
    rq_count = 0;
    running = '0;
    present[0] = 1'b1;
    tstat[0] = TS_RUNNING;
    quanta[0] = 32'd1;
  endfunction

  function automatic void schedule(sched_op_t it);
    sched_res_t r;
    bit         known;
    bit   [6:0] cur;
    r.status = ST_OK;
    r.rid = it.tid;
    known = present[it.tid];
    case (it.op)
      OP_SPAWN: begin
        r.status = ST_FULL;
        for (int i = 0; i < SPAWN_IDS && i < NTHR; i++) begin
          if (!present[i]) begin
            present[i] = 1'b1;
            tstat[i] = TS_READY;
            asleep[i] = 1'b0;
            quanta[i] = '0;
            rq_push(7'(i));
            r.status = ST_OK;
            r.rid = 7'(i);
            break;
          end
        end
      end
      OP_TERMINATE, OP_BLOCK, OP_RESUME: begin
        if (!known) begin
          r.status = ST_NOT_FOUND;
        end else if (it.op == OP_TERMINATE) begin
          present[it.tid] = 1'b0;
          asleep[it.tid] = 1'b0;
          rq_remove(it.tid);
        end else if (it.op == OP_BLOCK) begin
          tstat[it.tid] = TS_BLOCKED;
          rq_remove(it.tid);
        end else if (tstat[it.tid] != TS_BLOCKED) begin
          r.status = ST_IGNORED;
        end else if (it.tid == running) begin
          tstat[it.tid] = TS_RUNNING;
        end else begin
          tstat[it.tid] = TS_READY;
          if (!asleep[it.tid]) rq_push(it.tid);
        end
      end
      OP_SWITCH: begin
        cur = running;
        if (it.sl) begin
          asleep[cur] = 1'b1;
          sleep_cnt[cur] = it.ticks;
        end
        if (rq_count == 0 && it.te && cur != 0) begin
          running = '0;
          tstat[0] = TS_RUNNING;
          add_quantum(7'd0);
        end else if (rq_count == 0) begin
          add_quantum(cur);
        end else begin
          if (!(it.sl || it.bl || it.te)) begin
            tstat[cur] = TS_READY;
            rq_push(cur);
          end
          if (it.bl) tstat[cur] = TS_BLOCKED;
          running = ready_q[rq_head];
          rq_head = rq_head + 7'd1;
          rq_count--;
          tstat[running] = TS_RUNNING;
          add_quantum(running);
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NTHR; i++) begin
          if (asleep[i]) begin
            if (sleep_cnt[i] == {8'd0, wake_lvl}) begin
              asleep[i] = 1'b0;
              if (tstat[i] != TS_BLOCKED && i != running) begin
                tstat[i] = TS_READY;
                rq_push(7'(i));
              end
            end else begin
              sleep_cnt[i] = sleep_cnt[i] - 16'd1;
            end
          end
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    r.run = running;
    r.quanta = quanta[running];
    expected_res.insert(expected_res.size(), r);
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      schedule(take_op());
      op_taken = 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transaction: %h", m_tdata);
      end else begin
        e = expected_res[0];
        expected_res.delete(0);
        if (m_tdata[1:0] != e.status || m_tdata[8:2] != e.rid ||
            m_tdata[15:9] != e.run || m_tdata[47:16] != e.quanta) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: status %0d/%0d id %0d/%0d run %0d/%0d quanta %0d/%0d",
                     e.status, m_tdata[1:0], e.rid, m_tdata[8:2], e.run,
                     m_tdata[15:9], e.quanta, m_tdata[47:16]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic bit pause_now();
    return !calm && ($urandom_range(99) < 38);
  endfunction

  always @(negedge clk) begin
    sched_op_t it;
    if (!rst) begin
      m_tready <= !pause_now();
      if (!s_tvalid || op_taken) begin
        op_taken = 1'b0;
        if (op_queue.size() > 0 && !pause_now()) begin
          it = op_queue[0];
          s_tvalid <= 1'b1;
          s_tdata <= {3'b000, it.ticks, it.te, it.bl, it.sl, it.tid, it.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic add_op(op_t op, bit [6:0] tid, bit sl, bit bl, bit te,
                        bit [15:0] ticks);
    sched_op_t it;
    it.op = op;
    it.tid = tid;
    it.sl = sl;
    it.bl = bl;
    it.te = te;
    it.ticks = ticks;
    op_queue.insert(op_queue.size(), it);
  endtask

  task automatic drain();
    while (op_queue.size() > 0 || s_tvalid || expected_res.size() > 0)
      @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic set_wake_level(bit [7:0] lvl);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= WAKE_ADDR;
    pwdata <= {24'd0, lvl};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    wake_lvl = lvl;
  endtask

  task automatic add_random_ops(int n);
    int   pick;
    bit [6:0]  tid;
    bit [15:0] ticks;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      tid = ($urandom_range(9) < 8) ? 7'($urandom_range(15)) : 7'($urandom_range(127));
      ticks = ($urandom_range(7) == 0) ? 16'($urandom)
                                       : 16'(wake_lvl + $urandom_range(6));
      if (pick < 18)
        add_op(OP_SPAWN, 7'($urandom_range(127)), 0, 0, 0, 16'($urandom));
      else if (pick < 28)
        add_op(OP_TERMINATE, tid, 0, 0, 0, '0);
      else if (pick < 38)
        add_op(OP_BLOCK, tid, 0, 0, 0, '0);
      else if (pick < 52)
        add_op(OP_RESUME, tid, 0, 0, 0, '0);
      else if (pick < 82)
        add_op(OP_SWITCH, 7'($urandom_range(127)), $urandom_range(3) == 0,
               $urandom_range(6) == 0, $urandom_range(6) == 0, ticks);
      else
        add_op(OP_TICK, 7'($urandom_range(127)), 1'($urandom_range(1)),
               1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom));
    end
  endtask

  initial begin
    bit [7:0] levels [5];
    levels = '{8'd3, 8'd0, 8'd128, 8'd1, 8'd255};
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_wake_level(8'd0);

    add_op(OP_SWITCH, 7'd0, 0, 0, 1, '0);
    add_op(OP_SPAWN, 7'd127, 0, 0, 0, '0);
    add_op(OP_RESUME, 7'd1, 0, 0, 0, '0);
    add_op(OP_BLOCK, 7'd1, 0, 0, 0, '0);
    add_op(OP_RESUME, 7'd1, 0, 0, 0, '0);
    add_op(OP_TERMINATE, 7'd127, 0, 0, 0, '0);
    add_op(OP_BLOCK, 7'd100, 0, 0, 0, '0);
    add_op(OP_RESUME, 7'd64, 0, 0, 0, '0);
    add_op(OP_SPAWN, 7'd0, 0, 0, 0, '0);
    add_op(OP_SWITCH, 7'd0, 0, 0, 0, '0);
    add_op(OP_SWITCH, 7'd127, 1, 0, 0, 16'd2);
    add_op(OP_TICK, 7'd0, 0, 0, 0, '0);
    add_op(OP_TICK, 7'd0, 0, 0, 0, '0);
    add_op(OP_TICK, 7'd0, 0, 0, 0, '0);
    add_op(OP_SWITCH, 7'd0, 0, 1, 0, '0);
    add_op(OP_RESUME, 7'd1, 0, 0, 0, '0);
    add_op(OP_RESUME, 7'd2, 0, 0, 0, '0);
    add_op(OP_SWITCH, 7'd0, 1, 1, 1, 16'hFFFF);
    add_op(OP_TICK, 7'd127, 1, 1, 1, 16'hFFFF);
    add_op(OP_TERMINATE, 7'd2, 0, 0, 0, '0);
    add_op(OP_SWITCH, 7'd0, 0, 0, 1, '0);
    add_op(OP_TERMINATE, 7'd0, 0, 0, 0, '0);
    add_op(OP_SWITCH, 7'd0, 0, 0, 1, '0);
    drain();

    set_wake_level(8'd255);
    calm = 1'b1;
    for (int k = 0; k < 105; k++) add_op(OP_SPAWN, 7'($urandom_range(127)), 0, 0, 0, '0);
    add_random_ops(220);
    drain();
    calm = 1'b0;

    foreach (levels[p]) begin
      set_wake_level(levels[p]);
      add_random_ops(180);
      drain();
    end

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
